FILE: src/signed_int_to_decimal_ascii_macros.svh
// Assertion macros used by the checker file.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SIDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sida assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SIDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sida assertion failed");

`endif

FILE: src/sida_pkg.sv
// Shared constants and controller/datapath handshake types.
package sida_pkg;

  localparam int DATA_W     = 32;
  localparam int CHAR_W     = 8;
  localparam int NUM_DIGITS = 10;
  localparam int PTR_W      = 4;
  localparam int STEP_W     = 5;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic load;   // take a new value
    logic shift;  // one double-dabble step
    logic scan;   // locate leading digit
    logic emit;   // load next character into output register
  } sida_cmd_t;

  typedef struct packed {
    logic final_char;  // next character emitted is the last one
  } sida_status_t;

endpackage

FILE: src/sida_ifs.sv
// Valid/ready stream interfaces for the input value and output characters.
interface sida_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sida_out_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                char_code;
  logic                      last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

FILE: src/sida_ctrl.sv
// Sequencer: load, 32 conversion steps, leading-digit scan, character emission.
module sida_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  sida_pkg::sida_status_t status,
  output sida_pkg::sida_cmd_t    cmd
);
  import sida_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;
  logic              emit;

  assign in_ready = (state == ST_IDLE);
  assign emit     = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    cmd.load  = in_valid && in_ready;
    cmd.shift = (state == ST_CONV);
    cmd.scan  = (state == ST_SCAN);
    cmd.emit  = emit;
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        step_next = step + STEP_W'(1);
        if (step == {STEP_W{1'b1}}) state_next = ST_SCAN;
      end
      ST_SCAN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit && status.final_char) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (emit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: src/sida_dp.sv
// Datapath: magnitude, BCD shift register, digit pointer, output character register.
module sida_dp (
  input  logic                         clk,
  input  sida_pkg::sida_cmd_t          cmd,
  input  logic [sida_pkg::DATA_W-1:0]  value,
  output sida_pkg::sida_status_t       status,
  output logic [sida_pkg::CHAR_W-1:0]  char_code,
  output logic                         last
);
  import sida_pkg::*;

  logic [DATA_W-1:0]               mag;
  logic [NUM_DIGITS-1:0][3:0]      bcd;
  logic [NUM_DIGITS-1:0][3:0]      bcd_adj;
  logic                            sign_pend;
  ptr_t                            ptr;
  ptr_t                            lead;
  logic [3:0]                      cur_digit;

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // highest non-zero digit; zero keeps a single digit
  always_comb begin
    lead = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i] != 4'd0) lead = PTR_W'(i);
    end
  end

  assign cur_digit         = bcd[ptr];
  assign status.final_char = !sign_pend && (ptr == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag       <= value[DATA_W-1] ? (~value + DATA_W'(1)) : value;
      bcd       <= '0;
      sign_pend <= value[DATA_W-1];
    end else if (cmd.shift) begin
      {bcd, mag} <= {bcd_adj, mag} << 1;
    end
    if (cmd.scan) ptr <= lead;
    if (cmd.emit) begin
      if (sign_pend) begin
        char_code <= CHAR_MINUS;
        last      <= 1'b0;
        sign_pend <= 1'b0;
      end else begin
        char_code <= CHAR_ZERO + {4'd0, cur_digit};
        last      <= (ptr == '0);
        ptr       <= ptr - PTR_W'(1);
      end
    end
  end

endmodule

FILE: src/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
//   channel  dir  payload                    transfer when
//   din      in   value (32b signed)         din.valid && din.ready
//   dout     out  char_code (8b), last (1b)  dout.valid && dout.ready
//
// Order: a value is loaded, run through 32 double-dabble steps and a
// leading-digit scan, then sent as 1 to 11 characters at one per cycle
// unless dout stalls; the datapath's shift-and-add-3 loop does the work.
// din.ready is high only while the sequencer is idle; the last character
// may still sit in the output register while the next value is taken.
// A stall on dout freezes emission; nothing is dropped or repeated.
// Reset (rst, synchronous) returns the sequencer to idle and empties dout.
module signed_int_to_decimal_ascii (
  input  logic   clk,
  input  logic   rst,
  sida_in_if.sink    din,
  sida_out_if.source dout
);
  import sida_pkg::*;

  sida_cmd_t    cmd;
  sida_status_t status;

  // sequencer: owns handshakes and step counting
  sida_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: conversion and character register
  sida_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .value     (DATA_W'(din.value)),
    .status    (status),
    .char_code (dout.char_code),
    .last      (dout.last)
  );

endmodule

FILE: src/sida_checker.sv
// Port-level checks on the converter, bound to the top level.
`include "signed_int_to_decimal_ascii_macros.svh"

module sida_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] char_code,
  input logic       last
);

  // a stalled character holds
  `SIDA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_code) && $stable(last))

  // only minus or decimal digits appear
  `SIDA_ASSERT_NOW(a_char_set, out_valid, char_code == 8'd45 || (char_code >= 8'd48 && char_code <= 8'd57))

  // the sign never ends a text
  `SIDA_ASSERT_NOW(a_sign_not_last, out_valid && char_code == 8'd45, !last)

  // one value at a time: input closes after a transfer
  `SIDA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .char_code (dout.char_code),
  .last      (dout.last)
);
